// ===== sv/animated_tile_region_lookup_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the animated tile region lookup block
// Immediate-implication and next-cycle-implication checks, clocked on i_clk,
// off while i_rst_n is low. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ANIMATED_TILE_REGION_LOOKUP_TOP_ASSERT_SVH
`define ANIMATED_TILE_REGION_LOOKUP_TOP_ASSERT_SVH

`ifndef SYNTH

// ante holds -> cons holds in the same cycle
`define ATRL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds -> cons holds in the next cycle
`define ATRL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ATRL_ASSERT_IMP(lbl, ante, cons, msg)
`define ATRL_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/atrl_pkg.sv =====
// ----------------------------------------------------------------------------
// atrl_pkg
// Sizes, codes and shared types of the animated tile region lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package atrl_pkg;

    // table sizes
    localparam int TILES  = 256;
    localparam int ANIMS  = 16;
    localparam int FRAMES = 16;

    localparam int TILE_W  = (TILES > 1) ? $clog2(TILES) : 1;
    localparam int SLOT_W  = (ANIMS > 1) ? $clog2(ANIMS) : 1;
    localparam int ACNT_W  = $clog2(ANIMS + 1);
    localparam int FCNT_W  = $clog2(FRAMES + 1);
    localparam int FADDR_W = (ANIMS * FRAMES > 1) ? $clog2(ANIMS * FRAMES) : 1;

    // field widths
    localparam int FTILE_W = 8;
    localparam int DUR_W   = 16;
    localparam int TOT_W   = $clog2(FRAMES * ((1 << DUR_W) - 1) + 1);
    localparam int GID_W   = 32;
    localparam int TIME_W  = 32;
    localparam int COLS_W  = 9;
    localparam int TCNT_W  = 9;
    localparam int PIX_W   = 11;
    localparam int OFS_W   = 18;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 48;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // divider
    localparam int DIV_NUM_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // item kinds
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_GID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] quo;
        logic [COLS_W-1:0]    rem;
    } t_div_res;

    typedef struct packed {
        logic [FTILE_W-1:0] tile;
        logic [DUR_W-1:0]   dur;
    } t_frame;

endpackage

`default_nettype wire

// ===== sv/atrl_ram.sv =====
// ----------------------------------------------------------------------------
// atrl_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module atrl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/atrl_div.sv =====
// ----------------------------------------------------------------------------
// atrl_div
// Restoring divider, one quotient bit per cycle: 32-bit id by column count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "animated_tile_region_lookup_top_assert.svh"

module atrl_div import atrl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_dividend,
    input  logic [COLS_W-1:0]    i_divisor,
    output t_div_stat            o_stat,
    output t_div_res             o_res
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [COLS_W-1:0]    r_rem;
    logic [COLS_W-1:0]    r_div;

    logic [COLS_W:0]      w_sh;
    logic [COLS_W:0]      w_diff;
    logic                 w_ge;
    logic [COLS_W-1:0]    n_rem;
    logic                 w_last;

    // shift in the next dividend bit and try the subtract
    assign w_sh   = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};
    assign n_rem  = w_ge ? w_diff[COLS_W-1:0] : w_sh[COLS_W-1:0];
    assign w_last = (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath: quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res.quo   = r_quo;
    assign o_res.rem   = r_rem;

    `ATRL_ASSERT_IMP(a_div_start_idle, i_start, !r_busy, "divider restarted while busy")
    `ATRL_ASSERT_NXT(a_div_done_after_last, r_busy && w_last, r_done && !r_busy, "divider did not finish")
    `ATRL_ASSERT_NXT(a_div_done_pulse, r_done, !r_done, "divider done held")

endmodule

`default_nettype wire

// ===== sv/animated_tile_region_lookup_top.sv =====
// ----------------------------------------------------------------------------
// animated_tile_region_lookup_top
// Tile-set lookup with animated tiles: appends animation frames and maps a
// global id to the displayed tile and its pixel offset in the sheet.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake               Payload
//  -------   ---  ----------------------  ---------------------------------
//  s (items) in   i_s_tvalid/o_s_tready   tuser op; tdata anim_tile,
//                                         frame_tile, duration_ms, gid, now_ms
//  m (items) out  o_m_tvalid/i_m_tready   tdata accepted, shown_tile,
//                                         offset_x, offset_y, in_range
//  cfg       in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  Add-frame item: slot table read, update, result load.
//  Lookup item: slot table read, one frame memory read per visited frame
//  (0..16 frames), bit-serial divide by the column count, result load.
//  One item is in work at a time; the next is taken as soon as the result
//  sits in the output register, even while the output is stalled.
//  i_rst_n is synchronous: tile valid bits, animation counters and all
//  control clear together; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "animated_tile_region_lookup_top_assert.svh"

module animated_tile_region_lookup_top import atrl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [7:0] anim_tile, [15:8] frame_tile, [31:16] duration_ms,
    // [63:32] gid, [95:64] now_ms
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // [0] op
    input  logic                  i_s_tuser,
    // result items
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] accepted, [8:1] shown_tile, [26:9] offset_x, [44:27] offset_y,
    // [45] in_range, [47:46] zero
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD      = 3'd1;
    localparam logic [2:0] S_LK_SLOT  = 3'd2;
    localparam logic [2:0] S_WALK     = 3'd3;
    localparam logic [2:0] S_DIV_GO   = 3'd4;
    localparam logic [2:0] S_DIV_WAIT = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // configuration
    logic [GID_W-1:0]  r_first_gid;
    logic [TCNT_W-1:0] r_tile_count;
    logic [COLS_W-1:0] r_columns;
    logic [PIX_W-1:0]  r_tile_width;
    logic [PIX_W-1:0]  r_tile_height;

    // animation state
    logic [TILES-1:0]  r_tile_valid;
    logic [ACNT_W-1:0] r_anims_used;
    logic [FCNT_W-1:0] r_frames [ANIMS];
    logic [TOT_W-1:0]  r_total  [ANIMS];
    logic [TIME_W-1:0] r_start  [ANIMS];

    // item registers
    logic               r_is_add;
    logic               r_tile_ok;
    logic [TILE_W-1:0]  r_tile;
    logic [FTILE_W-1:0] r_ftile;
    logic [DUR_W-1:0]   r_dur;
    logic [TIME_W-1:0]  r_now;
    logic [GID_W-1:0]   r_local;
    logic               r_anim;
    logic               r_inr;
    logic               r_acc;
    logic [GID_W-1:0]   r_shown;

    // frame walk
    logic [FADDR_W-1:0] r_base;
    logic [TOT_W-1:0]   r_elapsed;
    logic [TOT_W-1:0]   r_sum;
    logic [FCNT_W-1:0]  r_k;
    logic [FCNT_W-1:0]  r_nfr;

    // output register
    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    // input unpack
    logic [FTILE_W-1:0] w_in_anim;
    logic [FTILE_W-1:0] w_in_ftile;
    logic [DUR_W-1:0]   w_in_dur;
    logic [GID_W-1:0]   w_in_gid;
    logic [TIME_W-1:0]  w_in_now;
    logic               w_in_acc;
    logic [GID_W-1:0]   w_in_local;
    logic               w_in_local_ok;
    logic               w_in_inr;

    assign w_in_anim  = i_s_tdata[7:0];
    assign w_in_ftile = i_s_tdata[15:8];
    assign w_in_dur   = i_s_tdata[31:16];
    assign w_in_gid   = i_s_tdata[63:32];
    assign w_in_now   = i_s_tdata[95:64];

    assign o_s_tready    = (r_state == S_IDLE);
    assign w_in_acc      = i_s_tvalid && o_s_tready;
    assign w_in_local    = w_in_gid - r_first_gid;
    assign w_in_local_ok = (w_in_local < GID_W'(TILES));
    // range check with the upper bound formed one bit wider
    assign w_in_inr = ({1'b0, r_first_gid} <= {1'b0, w_in_gid}) &&
                      ({1'b0, w_in_gid} < ({1'b0, r_first_gid} + (GID_W + 1)'(r_tile_count)));

    // tile -> slot memory
    logic              w_slot_re;
    logic [TILE_W-1:0] w_slot_raddr;
    logic [SLOT_W-1:0] w_slot_rdata;
    logic              w_slot_we;

    assign w_slot_re    = w_in_acc;
    assign w_slot_raddr = (i_s_tuser == OP_ADD) ? TILE_W'(w_in_anim) : TILE_W'(w_in_local);

    // add-frame decision
    logic              w_tv;
    logic              w_alloc;
    logic              w_have;
    logic [SLOT_W-1:0] w_slot;
    logic [FCNT_W-1:0] w_fc;
    logic [TOT_W-1:0]  w_tot_base;
    logic              w_store;

    assign w_tv       = r_tile_valid[r_tile];
    assign w_alloc    = (r_state == S_ADD) && r_tile_ok && !w_tv &&
                        (r_anims_used < ACNT_W'(ANIMS));
    assign w_have     = r_tile_ok && (w_tv || w_alloc);
    assign w_slot     = w_alloc ? SLOT_W'(r_anims_used) : w_slot_rdata;
    assign w_fc       = w_alloc ? '0 : r_frames[w_slot];
    assign w_tot_base = w_alloc ? '0 : r_total[w_slot];
    assign w_store    = (r_state == S_ADD) && w_have && (w_fc < FCNT_W'(FRAMES));
    assign w_slot_we  = w_alloc;

    // lookup: elapsed time and restart
    logic [TIME_W-1:0]  w_elap32;
    logic               w_restart;
    logic [FADDR_W-1:0] w_lk_base;

    assign w_elap32  = r_now - r_start[w_slot];
    assign w_restart = (w_elap32 > TIME_W'(r_total[w_slot]));
    assign w_lk_base = FADDR_W'(w_slot) * FADDR_W'(FRAMES);

    // frame memory ports
    logic               w_fm_we;
    logic [FADDR_W-1:0] w_fm_waddr;
    t_frame             w_fm_wdata;
    logic               w_fm_re;
    logic [FADDR_W-1:0] w_fm_raddr;
    t_frame             w_fm_rdata;

    assign w_fm_we         = w_store;
    assign w_fm_waddr      = w_lk_base + FADDR_W'(w_fc);
    assign w_fm_wdata.tile = r_ftile;
    assign w_fm_wdata.dur  = r_dur;
    assign w_fm_re         = (r_state == S_LK_SLOT) || (r_state == S_WALK);
    assign w_fm_raddr      = (r_state == S_LK_SLOT) ? w_lk_base :
                             (r_base + FADDR_W'(r_k) + FADDR_W'(1));

    // frame walk step
    logic [TOT_W-1:0]  w_end;
    logic              w_hit;
    logic [FCNT_W-1:0] w_k_next;

    assign w_end    = r_sum + TOT_W'(w_fm_rdata.dur);
    assign w_hit    = (r_elapsed < w_end);
    assign w_k_next = r_k + FCNT_W'(1);

    // divider
    logic              w_div_start;
    logic [COLS_W-1:0] w_cols;
    t_div_stat         w_div_stat;
    t_div_res          w_div_res;

    assign w_div_start = (r_state == S_DIV_GO);
    assign w_cols      = (r_columns == '0) ? COLS_W'(1) : r_columns;

    // result assembly
    logic                     w_out_load;
    logic [PIX_W+COLS_W-1:0]  w_ox_full;
    logic [PIX_W+OFS_W-1:0]   w_oy_full;
    logic [M_TDATA_W-1:0]     w_out_data;

    assign w_out_load = (r_state == S_DONE) && (!r_m_tvalid || i_m_tready);
    assign w_ox_full  = (PIX_W + COLS_W)'(r_tile_width) * (PIX_W + COLS_W)'(w_div_res.rem);
    assign w_oy_full  = (PIX_W + OFS_W)'(r_tile_height) *
                        (PIX_W + OFS_W)'(w_div_res.quo[OFS_W-1:0]);
    assign w_out_data = r_is_add ?
                        {{(M_TDATA_W - 1){1'b0}}, r_acc} :
                        {2'b00, r_inr, w_oy_full[OFS_W-1:0], w_ox_full[OFS_W-1:0],
                         r_shown[FTILE_W-1:0], r_acc};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_s_tuser == OP_ADD) ? S_ADD : S_LK_SLOT;
                end
            end
            S_ADD: begin
                n_state = S_DONE;
            end
            S_LK_SLOT: begin
                if (r_anim && (r_frames[w_slot] != '0)) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_DIV_GO;
                end
            end
            S_WALK: begin
                if (w_hit || (w_k_next == r_nfr)) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tile_valid <= '0;
            r_anims_used <= '0;
            r_m_tvalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_alloc) begin
                r_tile_valid[r_tile] <= 1'b1;
                r_anims_used         <= r_anims_used + ACNT_W'(1);
            end
            if (w_out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_gid   <= GID_W'(1);
            r_tile_count  <= '0;
            r_columns     <= COLS_W'(1);
            r_tile_width  <= PIX_W'(16);
            r_tile_height <= PIX_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FIRST_GID:   r_first_gid   <= i_cfg_data[GID_W-1:0];
                REG_TILE_COUNT:  r_tile_count  <= i_cfg_data[TCNT_W-1:0];
                REG_COLUMNS:     r_columns     <= i_cfg_data[COLS_W-1:0];
                REG_TILE_WIDTH:  r_tile_width  <= i_cfg_data[PIX_W-1:0];
                REG_TILE_HEIGHT: r_tile_height <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // per-animation counters and start times
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ANIMS; i++) begin
                r_frames[i] <= '0;
                r_total[i]  <= '0;
                r_start[i]  <= '0;
            end
        end else begin
            if (w_alloc || w_store) begin
                r_frames[w_slot] <= w_store ? (w_fc + FCNT_W'(1)) : w_fc;
                r_total[w_slot]  <= w_store ? (w_tot_base + TOT_W'(r_dur)) : w_tot_base;
            end
            if (w_alloc) begin
                r_start[w_slot] <= r_now;
            end
            if ((r_state == S_LK_SLOT) && r_anim && w_restart) begin
                r_start[w_slot] <= r_now;
            end
        end
    end

    // item and walk payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_is_add  <= (i_s_tuser == OP_ADD);
            r_tile_ok <= (GID_W'(w_in_anim) < GID_W'(TILES));
            r_tile    <= TILE_W'(w_in_anim);
            r_ftile   <= w_in_ftile;
            r_dur     <= w_in_dur;
            r_now     <= w_in_now;
            r_local   <= w_in_local;
            r_anim    <= w_in_local_ok && r_tile_valid[TILE_W'(w_in_local)];
            r_inr     <= w_in_inr;
            r_acc     <= (i_s_tuser == OP_LOOKUP);
        end
        if (r_state == S_ADD) begin
            r_acc <= w_store;
        end
        if (r_state == S_LK_SLOT) begin
            r_elapsed <= w_restart ? '0 : w_elap32[TOT_W-1:0];
            r_nfr     <= r_frames[w_slot];
            r_sum     <= '0;
            r_k       <= '0;
            r_base    <= w_lk_base;
            r_shown   <= r_anim ? '0 : r_local;
        end
        if (r_state == S_WALK) begin
            r_sum <= w_end;
            r_k   <= w_k_next;
            if (w_hit) begin
                r_shown <= GID_W'(w_fm_rdata.tile);
            end
        end
        if (w_out_load) begin
            r_m_tdata <= w_out_data;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // tile -> animation slot
    atrl_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TILES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (r_tile),
        .i_wdata (w_slot),
        .i_re    (w_slot_re),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rdata)
    );

    // frame tile and duration, addressed slot * FRAMES + frame
    atrl_ram #(
        .WIDTH ($bits(t_frame)),
        .DEPTH (ANIMS * FRAMES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_fm_we),
        .i_waddr (w_fm_waddr),
        .i_wdata (w_fm_wdata),
        .i_re    (w_fm_re),
        .i_raddr (w_fm_raddr),
        .o_rdata (w_fm_rdata)
    );

    atrl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_shown),
        .i_divisor  (w_cols),
        .o_stat     (w_div_stat),
        .o_res      (w_div_res)
    );

    `ATRL_ASSERT_IMP(a_anims_bound, 1'b1, r_anims_used <= ACNT_W'(ANIMS), "slot count overflow")
    `ATRL_ASSERT_IMP(a_walk_in_anim, r_state == S_WALK, r_k < r_nfr, "frame walk past end")
    `ATRL_ASSERT_NXT(a_alloc_step, w_alloc, r_anims_used == $past(r_anims_used) + 1'b1, "slot alloc lost")

endmodule

`default_nettype wire

// ===== tb/sv/animated_tile_region_lookup_top_tb.sv =====
// ----------------------------------------------------------------------------
// animated_tile_region_lookup_top_tb
// Self-checking bench for the animated tile lookup block. A queue of add-frame
// and lookup items feeds a stream driver; every accepted item runs through a
// local copy of the tile set and its animation table, and the monitor checks
// each returned item field by field against the oldest pending prediction.
// Sheet geometry is rewritten between phases, and both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module animated_tile_region_lookup_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import atrl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_PAUSE      = 64;
    localparam int HOT_TILES      = 20;

    // one input item
    typedef struct {
        logic               op;
        logic [FTILE_W-1:0] anim_tile;
        logic [FTILE_W-1:0] frame_tile;
        logic [DUR_W-1:0]   dur;
        logic [GID_W-1:0]   gid;
        logic [TIME_W-1:0]  now_ms;
        bit                 hold;     // wait for all results before sending
    } t_req;

    // one result item
    typedef struct {
        logic               accepted;
        logic [FTILE_W-1:0] shown;
        logic [OFS_W-1:0]   ox;
        logic [OFS_W-1:0]   oy;
        logic               inr;
    } t_res;

    // DUT ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  i_m_tready  = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_cfg_ready;

    // sheet settings as the block should hold them
    logic [GID_W-1:0]  cfg_first_gid  = 32'd1;
    logic [TCNT_W-1:0] cfg_tile_count = '0;
    logic [COLS_W-1:0] cfg_columns    = 9'd1;
    logic [PIX_W-1:0]  cfg_tile_w     = 11'd16;
    logic [PIX_W-1:0]  cfg_tile_h     = 11'd16;

    // animation table copy
    bit                 tile_animated [TILES]         = '{default: 1'b0};
    int                 slot_of_tile  [TILES]         = '{default: 0};
    logic [FTILE_W-1:0] frame_tile_mem[ANIMS*FRAMES];
    logic [DUR_W-1:0]   frame_dur_mem [ANIMS*FRAMES];
    int                 frame_count   [ANIMS]         = '{default: 0};
    logic [31:0]        anim_total_ms [ANIMS]         = '{default: '0};
    logic [TIME_W-1:0]  anim_start_ms [ANIMS]         = '{default: '0};
    int                 slots_used                    = 0;

    // stimulus and scoreboard
    t_req               pending[$];
    t_res               shown_due[$];
    t_req               in_flight;
    t_res               result_want;
    int                 items_queued   = 0;
    int                 items_taken    = 0;
    int                 mismatches     = 0;
    int                 quiet_cycles   = 0;
    int                 send_idle_pct  = 0;
    int                 take_idle_pct  = 0;
    logic [TIME_W-1:0]  sim_clock_ms   = '0;
    logic [FTILE_W-1:0] hot_tiles[HOT_TILES];

    animated_tile_region_lookup_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Expected result of one item; updates the table copy as the block would
    function automatic t_res predict_shown(t_req it);
        t_res        r;
        int          s;
        int          idx;
        logic [31:0] loc;
        logic [31:0] cols;
        logic [31:0] elapsed;
        logic [31:0] run_sum;
        logic [31:0] run_end;
        logic [7:0]  frame_pick;
        logic [63:0] ox;
        logic [63:0] oy;
        logic [32:0] upper;
        bit          found;
        r = '{default: '0};
        if (it.op == OP_ADD) begin
            if (!tile_animated[it.anim_tile]) begin
                if (slots_used >= ANIMS) return r;
                s = slots_used;
                slots_used++;
                tile_animated[it.anim_tile] = 1'b1;
                slot_of_tile[it.anim_tile]  = s;
                frame_count[s]   = 0;
                anim_total_ms[s] = '0;
                anim_start_ms[s] = it.now_ms;
            end
            s = slot_of_tile[it.anim_tile];
            if (frame_count[s] >= FRAMES) return r;
            idx = s * FRAMES + frame_count[s];
            frame_tile_mem[idx] = it.frame_tile;
            frame_dur_mem[idx]  = it.dur;
            frame_count[s]++;
            anim_total_ms[s] = anim_total_ms[s] + it.dur;
            r.accepted = 1'b1;
            return r;
        end
        loc = it.gid - cfg_first_gid;
        if (loc < TILES && tile_animated[loc[TILE_W-1:0]]) begin
            s = slot_of_tile[loc[TILE_W-1:0]];
            elapsed = it.now_ms - anim_start_ms[s];
            // past the end: restart the animation at this time
            if (elapsed > anim_total_ms[s]) begin
                elapsed = '0;
                anim_start_ms[s] = it.now_ms;
            end
            run_sum    = '0;
            frame_pick = '0;
            found      = 1'b0;
            for (int k = 0; k < frame_count[s]; k++) begin
                run_end = run_sum + frame_dur_mem[s*FRAMES+k];
                if (!found && elapsed < run_end) begin
                    frame_pick = frame_tile_mem[s*FRAMES+k];
                    found      = 1'b1;
                end
                run_sum = run_end;
            end
            loc = {24'd0, frame_pick};
        end
        cols  = (cfg_columns == '0) ? 32'd1 : {23'd0, cfg_columns};
        ox    = 64'(cfg_tile_w) * 64'(loc % cols);
        oy    = 64'(cfg_tile_h) * 64'(loc / cols);
        upper = {1'b0, cfg_first_gid} + 33'(cfg_tile_count);
        r.accepted = 1'b1;
        r.shown    = loc[FTILE_W-1:0];
        r.ox       = ox[OFS_W-1:0];
        r.oy       = oy[OFS_W-1:0];
        r.inr      = ({1'b0, cfg_first_gid} <= {1'b0, it.gid}) && ({1'b0, it.gid} < upper);
        return r;
    endfunction

    // All fields random; callers overwrite what the op uses
    function automatic t_req noise_item();
        t_req it;
        it.op         = logic'($urandom_range(1));
        it.anim_tile  = FTILE_W'($urandom);
        it.frame_tile = FTILE_W'($urandom);
        it.dur        = DUR_W'($urandom);
        it.gid        = $urandom;
        it.now_ms     = $urandom;
        it.hold       = 1'b0;
        return it;
    endfunction

    // Mostly frames for a small set of tiles and lookups of those tiles, with
    // the time running forward in small steps so frames are swept through
    function automatic t_req random_item();
        t_req it;
        int   pick;
        it   = noise_item();
        pick = $urandom_range(99);
        if (pick < 3)
            sim_clock_ms = $urandom;
        else if (pick < 5)
            sim_clock_ms = sim_clock_ms - $urandom_range(1, 100);
        else
            sim_clock_ms = sim_clock_ms + $urandom_range(0, 12);
        it.now_ms = sim_clock_ms;
        if ($urandom_range(99) < 28) begin
            it.op = OP_ADD;
            if ($urandom_range(99) < 85)
                it.anim_tile = hot_tiles[$urandom_range(HOT_TILES-1)];
            pick = $urandom_range(99);
            if (pick < 70)
                it.dur = DUR_W'($urandom_range(0, 15));
            else if (pick < 88)
                it.dur = DUR_W'($urandom_range(16, 300));
            else if (pick < 92)
                it.dur = '1;
        end else begin
            it.op = OP_LOOKUP;
            pick  = $urandom_range(99);
            if (pick < 60)
                it.gid = cfg_first_gid + hot_tiles[$urandom_range(HOT_TILES-1)];
            else if (pick < 80)
                it.gid = cfg_first_gid + $urandom_range(0, 300);
            else if (pick < 90)
                it.gid = cfg_first_gid + cfg_tile_count - $urandom_range(0, 1);
        end
        it.hold = ($urandom_range(99) == 0);
        return it;
    endfunction

    task automatic queue_item(input t_req it);
        pending.insert(pending.size(), it);
        items_queued++;
    endtask

    task automatic queue_add(input logic [7:0] tile, input logic [7:0] ftile,
                             input logic [15:0] dur, input logic [31:0] now);
        t_req it;
        it = noise_item();
        it.op         = OP_ADD;
        it.anim_tile  = tile;
        it.frame_tile = ftile;
        it.dur        = dur;
        it.now_ms     = now;
        queue_item(it);
    endtask

    task automatic queue_lookup(input logic [31:0] gid, input logic [31:0] now);
        t_req it;
        it = noise_item();
        it.op     = OP_LOOKUP;
        it.gid    = gid;
        it.now_ms = now;
        queue_item(it);
    endtask

    // Every queued item accepted and every result back
    task automatic wait_idle();
        while (items_taken != items_queued || shown_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_FIRST_GID:   cfg_first_gid  = val;
            REG_TILE_COUNT:  cfg_tile_count = val[TCNT_W-1:0];
            REG_COLUMNS:     cfg_columns    = val[COLS_W-1:0];
            REG_TILE_WIDTH:  cfg_tile_w     = val[PIX_W-1:0];
            REG_TILE_HEIGHT: cfg_tile_h     = val[PIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_sheet(input logic [GID_W-1:0] first, input logic [TCNT_W-1:0] count,
                             input logic [COLS_W-1:0] cols, input logic [PIX_W-1:0] w,
                             input logic [PIX_W-1:0] h);
        write_reg(REG_FIRST_GID, first);
        write_reg(REG_TILE_COUNT, 32'(count));
        write_reg(REG_COLUMNS, 32'(cols));
        write_reg(REG_TILE_WIDTH, 32'(w));
        write_reg(REG_TILE_HEIGHT, 32'(h));
    endtask

    task automatic run_stage(input int send_pct, input int take_pct, input int count);
        t_req it;
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
        for (int i = 0; i < count; i++) begin
            it = random_item();
            if (i == 100) it.hold = 1'b1;
            queue_item(it);
        end
        wait_idle();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Item driver: predicts on acceptance, then offers the next queued item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                shown_due.insert(shown_due.size(), predict_shown(in_flight));
                items_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending.size() != 0 && (!pending[0].hold || shown_due.size() == 0) &&
                    $urandom_range(99) >= send_idle_pct) begin
                    in_flight = pending.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {in_flight.now_ms, in_flight.gid, in_flight.dur,
                                   in_flight.frame_tile, in_flight.anim_tile};
                    i_s_tuser  <= in_flight.op;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (shown_due.size() == 0) begin
                    $display("%0t: result item expected none, got %h", $time, o_m_tdata);
                    mismatches++;
                end else begin
                    result_want = shown_due.pop_front();
                    check_field("accepted", 32'(result_want.accepted), 32'(o_m_tdata[0]));
                    check_field("shown_tile", 32'(result_want.shown), 32'(o_m_tdata[8:1]));
                    check_field("offset_x", 32'(result_want.ox), 32'(o_m_tdata[26:9]));
                    check_field("offset_y", 32'(result_want.oy), 32'(o_m_tdata[44:27]));
                    check_field("in_range", 32'(result_want.inr), 32'(o_m_tdata[45]));
                end
            end
            i_m_tready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence
    initial begin
        hot_tiles[0] = 8'd3;
        hot_tiles[1] = 8'd255;
        hot_tiles[2] = 8'd0;
        for (int i = 3; i < HOT_TILES; i++)
            hot_tiles[i] = FTILE_W'($urandom_range(255));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 6;
        take_idle_pct = 83;

        // reset geometry: empty set, so nothing is in range; wrapped local id
        queue_lookup(32'd1, 32'd0);
        queue_lookup(32'd0, 32'd0);
        wait_idle();

        // 16 tiles per row; animations with a zero and a maximal frame
        set_sheet(32'd1, 9'd256, 9'd16, 11'd16, 11'd16);
        queue_add(8'd3, 8'd10, 16'd5, 32'd100);
        queue_add(8'd3, 8'd11, 16'd0, 32'd100);
        queue_add(8'd3, 8'd12, 16'hFFFF, 32'd100);
        queue_lookup(32'd4, 32'd100);
        queue_lookup(32'd4, 32'd105);          // zero-length frame skipped
        queue_lookup(32'd4, 32'd65640);        // elapsed equals total
        queue_lookup(32'd4, 32'd65641);        // past total, restarts
        queue_add(8'd255, 8'd255, 16'd0, 32'hFFFF_FFFF);
        queue_lookup(32'd256, 32'hFFFF_FFFF);  // all frames empty
        queue_lookup(32'd256, 32'd0);          // time wrap, restart
        queue_add(8'd0, 8'd200, 16'd1, 32'd0);
        queue_lookup(32'd1, 32'd0);
        queue_lookup(32'd257, 32'd0);          // local id past the table
        queue_lookup(32'd0, 32'd0);
        queue_lookup(32'hFFFF_FFFF, 32'd7);
        wait_idle();

        // set ends past 2^32: bound formed without wrap; widest tiles
        set_sheet(32'hFFFF_FF80, 9'd256, 9'd256, 11'd1024, 11'd1024);
        queue_lookup(32'hFFFF_FFFF, 32'd9);
        queue_lookup(32'd0, 32'd9);
        queue_lookup(32'hFFFF_FF83, 32'd200000);
        wait_idle();

        // zero columns act as one; empty set starting at zero
        set_sheet(32'd0, 9'd0, 9'd0, 11'd1, 11'd1);
        queue_lookup(32'd255, 32'd300000);
        queue_lookup(32'd200, 32'd300000);
        queue_lookup(32'd0, 32'd300000);
        wait_idle();

        // random phases
        set_sheet(32'd1, 9'd256, 9'd16, 11'd16, 11'd16);
        run_stage(6, 83, 300);
        set_sheet($urandom, TCNT_W'($urandom_range(0, 256)), COLS_W'($urandom_range(1, 256)),
                  PIX_W'($urandom_range(1, 1024)), PIX_W'($urandom_range(1, 1024)));
        run_stage(6, 83, 250);
        set_sheet(32'd1000, 9'd100, 9'd1, 11'd1024, 11'd1024);
        run_stage(83, 6, 300);
        set_sheet(32'hFFFF_FFFF, 9'd1, 9'd256, 11'd1, 11'd1024);
        run_stage(83, 6, 250);
        set_sheet($urandom, TCNT_W'($urandom_range(0, 256)), COLS_W'($urandom_range(1, 256)),
                  PIX_W'($urandom_range(1, 1024)), PIX_W'($urandom_range(1, 1024)));
        run_stage(0, 0, 300);
        set_sheet(32'd0, 9'd256, 9'd7, 11'd1023, 11'd1000);
        run_stage(0, 0, 300);

        repeat (END_PAUSE) @(posedge i_clk);
        if (mismatches == 0 && shown_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
